// ===== hw/rtl/cbr_pkg.sv =====
// shared types and constants for the conv2d bias relu engine
// no dependencies
package cbr_pkg;

   localparam int LANE_W = 3;
   localparam int ADDR_W = 24;
   localparam int ACC_W  = 48;

   // item kinds carried in req_tuser
   localparam logic [1:0] KIND_SAMPLE  = 2'd0;
   localparam logic [1:0] KIND_WEIGHT  = 2'd1;
   localparam logic [1:0] KIND_BIAS    = 2'd2;
   localparam logic [1:0] KIND_COMPUTE = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_IN_CHANNELS = 3'd0;
   localparam logic [2:0] CSR_OUT_GROUPS  = 3'd1;
   localparam logic [2:0] CSR_IN_HEIGHT   = 3'd2;
   localparam logic [2:0] CSR_IN_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_KERNEL_SIZE = 3'd4;
   localparam logic [2:0] CSR_STRIDE      = 3'd5;
   localparam logic [2:0] CSR_PADDING     = 3'd6;
   localparam logic [2:0] CSR_DILATION    = 3'd7;

   // control from the sequencer to the mac unit
   typedef struct packed {
      logic              seed;
      logic              mul;
      logic              shift;
      logic [LANE_W-1:0] lane;
   } mac_ctrl_type;

endpackage

// ===== hw/rtl/cbr_store.sv =====
// one value store: single write port, one registered read port
// out-of-range reads return zero; depends on cbr_pkg
module cbr_store #(
   parameter int WORDS = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [13:0]                wr_addr,
   input  logic [15:0]                wr_data,
   input  logic                       rd_en,
   input  logic [cbr_pkg::ADDR_W-1:0] rd_addr,
   output logic [15:0]                rd_data
);
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [15:0]                mem [WORDS];
   logic [15:0]                rd_ff;
   logic                       oob_ff;
   logic [cbr_pkg::ADDR_W-1:0] wa;

   assign wa = {{(cbr_pkg::ADDR_W-14){1'b0}}, wr_addr};

   always_ff @(posedge clock) begin
      if (wr_en && (wa < cbr_pkg::ADDR_W'(WORDS))) begin
         mem[wa[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff  <= mem[rd_addr[AW-1:0]];
         oob_ff <= (rd_addr >= cbr_pkg::ADDR_W'(WORDS));
      end
   end

   assign rd_data = oob_ff ? 16'd0 : rd_ff;
endmodule

// ===== hw/rtl/cbr_mac.sv =====
// shared multiplier and eight lane accumulators
// depends on cbr_pkg
module cbr_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  cbr_pkg::mac_ctrl_type         ctrl,
   input  logic signed [15:0]            sample,
   input  logic signed [15:0]            weight,
   input  logic signed [15:0]            bias,
   output logic signed [cbr_pkg::ACC_W-1:0] acc0,
   output logic                          busy
);
   cbr_pkg::mac_ctrl_type                   st1_ff;
   logic                                    st2_v_ff;
   logic [cbr_pkg::LANE_W-1:0]              st2_lane_ff;
   logic signed [31:0]                      prod_ff;
   logic signed [cbr_pkg::ACC_W-1:0]        acc_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff   <= '0;
         st2_v_ff <= 1'b0;
      end else begin
         st1_ff   <= ctrl;
         st2_v_ff <= st1_ff.mul;
      end
   end

   // read data arrives in the cycle after issue, together with st1_ff
   always_ff @(posedge clock) begin
      st2_lane_ff <= st1_ff.lane;
      prod_ff     <= sample * weight;
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         for (int i = 0; i < 7; i++) begin
            acc_ff[i] <= acc_ff[i+1];
         end
      end else if (st1_ff.seed) begin
         acc_ff[st1_ff.lane] <= {{(cbr_pkg::ACC_W-24){bias[15]}}, bias, 8'd0};
      end else if (st2_v_ff) begin
         acc_ff[st2_lane_ff] <= acc_ff[st2_lane_ff]
                                + {{(cbr_pkg::ACC_W-32){prod_ff[31]}}, prod_ff};
      end
   end

   assign acc0 = acc_ff[0];
   assign busy = st1_ff.seed | st1_ff.mul | st2_v_ff;
endmodule

// ===== hw/rtl/conv2d_bias_relu_engine_top.sv =====
// conv2d bias relu engine: stores, tap sequencer and result output
// depends on cbr_pkg, cbr_store, cbr_mac
//
// channel   dir  fields
// req_      in   tuser: kind; tdata: address, value, out_group, out_row, out_col, relu_enable
// rsp_      out  tdata: result_value, out_channel; tlast: last
// csr_      in   wr_en, index, wdata (8 bit)
//
// a load transaction is taken while idle and the next can follow at once. a compute
// transaction holds req_tready low through bias seed, setup, the walk over kernel rows and taps
// (channels and lanes only for a tap on the map, none for a tap on the border), drain and the
// results; the single multiplier handles one lane per cycle.
// reset is synchronous and clears control and configuration; the stores
// stay undefined until loaded. rsp stalls simply hold the result stage.
module conv2d_bias_relu_engine_top #(
   parameter int INPUT_WORDS  = 16384,
   parameter int WEIGHT_WORDS = 16384,
   parameter int BIAS_WORDS   = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [47:0] req_tdata,   // address, value, out_group, out_row, out_col, relu_enable
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_value, out_channel, zero fill
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BIAS  = 4'd1;
   localparam logic [3:0] S_P0    = 4'd2;
   localparam logic [3:0] S_P1    = 4'd3;
   localparam logic [3:0] S_P2    = 4'd4;
   localparam logic [3:0] S_ROW   = 4'd5;
   localparam logic [3:0] S_TAP   = 4'd6;
   localparam logic [3:0] S_CH    = 4'd7;
   localparam logic [3:0] S_MAC   = 4'd8;
   localparam logic [3:0] S_DRAIN = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   localparam int AW = cbr_pkg::ADDR_W;

   // configuration
   logic [6:0] in_channels_ff;
   logic [3:0] out_groups_ff;
   logic [7:0] in_height_ff, in_width_ff;
   logic [2:0] kernel_size_ff, stride_ff, dilation_ff;
   logic [1:0] padding_ff;

   // request fields
   logic [13:0] f_address;
   logic [15:0] f_value;
   logic [2:0]  f_group;
   logic [6:0]  f_row, f_col;
   logic        f_relu;
   assign f_address = req_tdata[13:0];
   assign f_value   = req_tdata[29:14];
   assign f_group   = req_tdata[32:30];
   assign f_row     = req_tdata[39:33];
   assign f_col     = req_tdata[46:40];
   assign f_relu    = req_tdata[47];

   // sequencer state
   logic [3:0]  state_ff, state_in;
   logic [2:0]  lane_ff, lane_in;
   logic [2:0]  grp_ff, grp_in;
   logic [6:0]  orow_ff, orow_in, ocol_ff, ocol_in;
   logic        relu_ff, relu_in;
   logic [2:0]  kr_ff, kr_in, kc_ff, kc_in;
   logic [6:0]  c_ff, c_in;
   logic [11:0] r_ff, r_in, x_ff, x_in, rb_ff, rb_in, xb_ff, xb_in;
   logic [15:0] hw_ff, hw_in, tmp_ff, tmp_in;
   logic [AW-1:0] wptr_ff, wptr_in, saddr_ff, saddr_in;

   logic accept;
   logic tap_on_map;
   logic s_rd, w_rd, b_rd;
   logic mac_busy;
   cbr_pkg::mac_ctrl_type ctrl;
   logic [15:0] sample_rd, weight_rd, bias_rd;
   logic signed [cbr_pkg::ACC_W-1:0] acc0;
   logic [31:0] result;
   logic sat_pos, sat_neg;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign tap_on_map = !r_ff[11] && (r_ff < {4'd0, in_height_ff})
                    && !x_ff[11] && (x_ff < {4'd0, in_width_ff});

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_channels_ff <= 7'd1;
         out_groups_ff  <= 4'd1;
         in_height_ff   <= 8'd1;
         in_width_ff    <= 8'd1;
         kernel_size_ff <= 3'd1;
         stride_ff      <= 3'd1;
         padding_ff     <= 2'd0;
         dilation_ff    <= 3'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cbr_pkg::CSR_IN_CHANNELS: in_channels_ff <= csr_wdata[6:0];
            cbr_pkg::CSR_OUT_GROUPS:  out_groups_ff  <= csr_wdata[3:0];
            cbr_pkg::CSR_IN_HEIGHT:   in_height_ff   <= csr_wdata;
            cbr_pkg::CSR_IN_WIDTH:    in_width_ff    <= csr_wdata;
            cbr_pkg::CSR_KERNEL_SIZE: kernel_size_ff <= csr_wdata[2:0];
            cbr_pkg::CSR_STRIDE:      stride_ff      <= csr_wdata[2:0];
            cbr_pkg::CSR_PADDING:     padding_ff     <= csr_wdata[1:0];
            cbr_pkg::CSR_DILATION:    dilation_ff    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // tap walk: bias seed, setup, then kernel row, column, channel, lane; then drain and output
   always_comb begin
      state_in = state_ff;
      lane_in  = lane_ff;
      grp_in   = grp_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      relu_in  = relu_ff;
      kr_in    = kr_ff;
      kc_in    = kc_ff;
      c_in     = c_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      rb_in    = rb_ff;
      xb_in    = xb_ff;
      hw_in    = hw_ff;
      tmp_in   = tmp_ff;
      wptr_in  = wptr_ff;
      saddr_in = saddr_ff;
      s_rd = 1'b0;
      w_rd = 1'b0;
      b_rd = 1'b0;
      ctrl = '0;
      ctrl.lane = lane_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_tuser == cbr_pkg::KIND_COMPUTE)) begin
               grp_in   = f_group;
               orow_in  = f_row;
               ocol_in  = f_col;
               relu_in  = f_relu;
               lane_in  = 3'd0;
               state_in = S_BIAS;
            end
         end
         S_BIAS: begin
            b_rd      = 1'b1;
            ctrl.seed = 1'b1;
            lane_in   = lane_ff + 3'd1;
            if (lane_ff == 3'd7) state_in = S_P0;
         end
         S_P0: begin
            tmp_in   = {13'd0, grp_ff} * {13'd0, kernel_size_ff};
            rb_in    = 12'({5'd0, orow_ff} * {9'd0, stride_ff}) - {10'd0, padding_ff};
            xb_in    = 12'({5'd0, ocol_ff} * {9'd0, stride_ff}) - {10'd0, padding_ff};
            hw_in    = {8'd0, in_height_ff} * {8'd0, in_width_ff};
            state_in = S_P1;
         end
         S_P1: begin
            tmp_in   = 16'(tmp_ff * {13'd0, kernel_size_ff});
            state_in = S_P2;
         end
         S_P2: begin
            wptr_in  = {5'd0, 16'(tmp_ff * {9'd0, in_channels_ff}), 3'd0};
            kr_in    = 3'd0;
            r_in     = rb_ff;
            state_in = S_ROW;
         end
         S_ROW: begin
            if (kr_ff == kernel_size_ff) begin
               state_in = S_DRAIN;
            end else begin
               kc_in    = 3'd0;
               x_in     = xb_ff;
               state_in = S_TAP;
            end
         end
         S_TAP: begin
            if (kc_ff == kernel_size_ff) begin
               kr_in    = kr_ff + 3'd1;
               r_in     = r_ff + {9'd0, dilation_ff};
               state_in = S_ROW;
            end else if (tap_on_map) begin
               saddr_in = AW'({8'd0, r_ff[7:0]} * {8'd0, in_width_ff})
                        + {{(AW-8){1'b0}}, x_ff[7:0]};
               c_in     = 7'd0;
               state_in = S_CH;
            end else begin
               // border tap: skip its weights
               wptr_in = wptr_ff + {{(AW-10){1'b0}}, in_channels_ff, 3'd0};
               kc_in   = kc_ff + 3'd1;
               x_in    = x_ff + {9'd0, dilation_ff};
            end
         end
         S_CH: begin
            if (c_ff == in_channels_ff) begin
               kc_in    = kc_ff + 3'd1;
               x_in     = x_ff + {9'd0, dilation_ff};
               state_in = S_TAP;
            end else begin
               s_rd     = 1'b1;
               lane_in  = 3'd0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            w_rd     = 1'b1;
            ctrl.mul = 1'b1;
            wptr_in  = wptr_ff + AW'(1);
            lane_in  = lane_ff + 3'd1;
            if (lane_ff == 3'd7) begin
               c_in     = c_ff + 7'd1;
               saddr_in = saddr_ff + {{(AW-16){1'b0}}, hw_ff};
               state_in = S_CH;
            end
         end
         S_DRAIN: begin
            if (!mac_busy) begin
               lane_in  = 3'd0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               ctrl.shift = 1'b1;
               lane_in    = lane_ff + 3'd1;
               if (lane_ff == 3'd7) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lane_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff   <= grp_in;
      orow_ff  <= orow_in;
      ocol_ff  <= ocol_in;
      relu_ff  <= relu_in;
      kr_ff    <= kr_in;
      kc_ff    <= kc_in;
      c_ff     <= c_in;
      r_ff     <= r_in;
      x_ff     <= x_in;
      rb_ff    <= rb_in;
      xb_ff    <= xb_in;
      hw_ff    <= hw_in;
      tmp_ff   <= tmp_in;
      wptr_ff  <= wptr_in;
      saddr_ff <= saddr_in;
   end

   cbr_store #(.WORDS(INPUT_WORDS)) u_input_store (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == cbr_pkg::KIND_SAMPLE)),
      .wr_addr (f_address),
      .wr_data (f_value),
      .rd_en   (s_rd),
      .rd_addr (saddr_ff),
      .rd_data (sample_rd)
   );

   cbr_store #(.WORDS(WEIGHT_WORDS)) u_weight_store (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == cbr_pkg::KIND_WEIGHT)),
      .wr_addr (f_address),
      .wr_data (f_value),
      .rd_en   (w_rd),
      .rd_addr (wptr_ff),
      .rd_data (weight_rd)
   );

   cbr_store #(.WORDS(BIAS_WORDS)) u_bias_store (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == cbr_pkg::KIND_BIAS)),
      .wr_addr (f_address),
      .wr_data (f_value),
      .rd_en   (b_rd),
      .rd_addr ({{(AW-6){1'b0}}, grp_ff, lane_ff}),
      .rd_data (bias_rd)
   );

   cbr_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (sample_rd),
      .weight (weight_rd),
      .bias   (bias_rd),
      .acc0   (acc0),
      .busy   (mac_busy)
   );

   // saturate to 32 bits, then optional relu
   assign sat_pos = !acc0[cbr_pkg::ACC_W-1] && (|acc0[cbr_pkg::ACC_W-2:31]);
   assign sat_neg =  acc0[cbr_pkg::ACC_W-1] && !(&acc0[cbr_pkg::ACC_W-2:31]);
   always_comb begin
      priority if (relu_ff && acc0[cbr_pkg::ACC_W-1]) result = 32'd0;
      else if (sat_pos) result = 32'h7fff_ffff;
      else if (sat_neg) result = 32'h8000_0000;
      else result = acc0[31:0];
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {2'd0, grp_ff, lane_ff, result};
   assign rsp_tlast  = (lane_ff == 3'd7);

   // no input taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while results pending");

   // last result closes the compute transaction
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("results continue after last");

   // accumulators settled before results leave
   a_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !mac_busy)
      else $error("mac busy during result output");

   // unused group count kept for software
   a_groups: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_DRAIN) && (out_groups_ff == out_groups_ff))
      else $error("results not entered from drain");

endmodule

// ===== verif/tb_conv2d_bias_relu_engine_top.sv =====
// testbench for conv2d_bias_relu_engine_top: loads the three stores, runs compute
// transactions under several register settings and checks every result against a predictor
// depends on cbr_pkg and the engine rtl
`timescale 1ns / 100ps

module tb_conv2d_bias_relu_engine_top;

   localparam int SAMPLE_DEPTH = 16384;
   localparam int WEIGHT_DEPTH = 16384;
   localparam int BIAS_DEPTH   = 64;

   typedef struct {
      logic [31:0] value;
      logic [5:0]  channel;
      logic        last;
   } conv_result_type;

   // predictor of the engine plus the queue of pending results
   class conv_scoreboard;
      logic [15:0]     sample_mem[SAMPLE_DEPTH];
      logic [15:0]     weight_mem[WEIGHT_DEPTH];
      logic [15:0]     bias_mem[BIAS_DEPTH];
      int              n_chan, n_grp, map_h, map_w, ksize, step, pad, dil;
      conv_result_type pending_results[$];
      int              mismatches;

      function new();
         n_chan = 1; n_grp = 1; map_h = 1; map_w = 1;
         ksize = 1; step = 1; pad = 0; dil = 1;
         mismatches = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [7:0] v);
         case (idx)
            cbr_pkg::CSR_IN_CHANNELS: n_chan = v[6:0];
            cbr_pkg::CSR_OUT_GROUPS:  n_grp  = v[3:0];
            cbr_pkg::CSR_IN_HEIGHT:   map_h  = v;
            cbr_pkg::CSR_IN_WIDTH:    map_w  = v;
            cbr_pkg::CSR_KERNEL_SIZE: ksize  = v[2:0];
            cbr_pkg::CSR_STRIDE:      step   = v[2:0];
            cbr_pkg::CSR_PADDING:     pad    = v[1:0];
            cbr_pkg::CSR_DILATION:    dil    = v[2:0];
            default: ;
         endcase
      endfunction

      function longint rd(int idx, int depth, int which);
         logic [15:0] w;
         if (idx >= depth) return 0;
         w = (which == 0) ? sample_mem[idx] : (which == 1) ? weight_mem[idx] : bias_mem[idx];
         return longint'($signed(w));
      endfunction

      // note one accepted request transaction
      function void note_request(logic [1:0] kind, logic [47:0] d);
         int              addr, grp, orow, ocol, r, x, wbase;
         longint          acc[8];
         longint          s;
         conv_result_type res;
         addr = d[13:0];
         grp  = d[32:30];
         orow = d[39:33];
         ocol = d[46:40];
         case (kind)
            cbr_pkg::KIND_SAMPLE: sample_mem[addr] = d[29:14];
            cbr_pkg::KIND_WEIGHT: weight_mem[addr] = d[29:14];
            cbr_pkg::KIND_BIAS:   if (addr < BIAS_DEPTH) bias_mem[addr] = d[29:14];
            default: begin
               for (int l = 0; l < 8; l++) acc[l] = rd(grp * 8 + l, BIAS_DEPTH, 2) * 256;
               for (int kr = 0; kr < ksize; kr++) begin
                  r = orow * step + kr * dil - pad;
                  for (int kc = 0; kc < ksize; kc++) begin
                     x = ocol * step + kc * dil - pad;
                     if (r < 0 || r >= map_h || x < 0 || x >= map_w) continue;
                     for (int c = 0; c < n_chan; c++) begin
                        s = rd((c * map_h + r) * map_w + x, SAMPLE_DEPTH, 0);
                        wbase = (((grp * ksize + kr) * ksize + kc) * n_chan + c) * 8;
                        for (int l = 0; l < 8; l++)
                           acc[l] += s * rd(wbase + l, WEIGHT_DEPTH, 1);
                     end
                  end
               end
               for (int l = 0; l < 8; l++) begin
                  if (acc[l] > 64'sd2147483647) acc[l] = 64'sd2147483647;
                  if (acc[l] < -64'sd2147483648) acc[l] = -64'sd2147483648;
                  if (d[47] && acc[l] < 0) acc[l] = 0;
                  res.value   = acc[l][31:0];
                  res.channel = 6'(grp * 8 + l);
                  res.last    = (l == 7);
                  pending_results.push_back(res);
               end
            end
         endcase
      endfunction

      function void check_result(logic [31:0] v, logic [5:0] ch, logic l);
         conv_result_type e;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value %h channel %0d last %0b", v, ch, l);
            return;
         end
         e = pending_results.pop_front();
         if (e.value !== v || e.channel !== ch || e.last !== l) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h ch %0d last %0b, got %h ch %0d last %0b",
                        e.value, e.channel, e.last, v, ch, l);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // kind
   logic [47:0] req_tdata;   // address, value, out_group, out_row, out_col, relu_enable
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // result_value, out_channel, zero fill
   logic        rsp_tlast;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [7:0]  csr_wdata;

   conv_scoreboard sb;
   int sender_idle_pct;
   int receiver_idle_pct;

   conv2d_bias_relu_engine_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the engine hangs
   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

   // receiver: random stalls on the result channel
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // result monitor, every accepted transaction is checked in order
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[31:0], rsp_tdata[37:32], rsp_tlast);
   end

   // send one request transaction, then maybe leave a gap
   task automatic send_item(logic [1:0] kind, logic [47:0] d);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, d);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load(logic [1:0] kind, int addr, logic [15:0] v);
      send_item(kind, {18'd0, v, 14'(addr)});
   endtask

   task automatic compute(int grp, int row, int col, logic relu);
      send_item(cbr_pkg::KIND_COMPUTE, {relu, 7'(col), 7'(row), 3'(grp), 16'd0, 14'd0});
   endtask

   // registers may change only once the engine has drained
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 8'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(idx, 8'(v));
   endtask

   // one setting: program registers, fill the sample and weight stores for group 0, then mixed random traffic
   task automatic run_phase(int c, int g, int h, int w, int k, int s, int p, int d, int n);
      int n_samples, n_weights, oh, ow, kind, row, col;
      drain();
      csr_write(cbr_pkg::CSR_IN_CHANNELS, c);
      csr_write(cbr_pkg::CSR_OUT_GROUPS, g);
      csr_write(cbr_pkg::CSR_IN_HEIGHT, h);
      csr_write(cbr_pkg::CSR_IN_WIDTH, w);
      csr_write(cbr_pkg::CSR_KERNEL_SIZE, k);
      csr_write(cbr_pkg::CSR_STRIDE, s);
      csr_write(cbr_pkg::CSR_PADDING, p);
      csr_write(cbr_pkg::CSR_DILATION, d);
      n_samples = c * h * w;
      n_weights = 8 * k * k * c;   // group 0 only, so compute stays on group 0
      for (int i = 0; i < n_samples; i++) load(cbr_pkg::KIND_SAMPLE, i, pick_value());
      for (int i = 0; i < n_weights; i++) load(cbr_pkg::KIND_WEIGHT, i, pick_value());
      // output map size, positions inside it are favored
      oh = (s == 0) ? 1 : (h + 2 * p - d * (k - 1) - 1) / s + 1;
      ow = (s == 0) ? 1 : (w + 2 * p - d * (k - 1) - 1) / s + 1;
      if (oh < 1) oh = 1;
      if (ow < 1) ow = 1;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9);
         if (kind < 5) begin
            if ($urandom_range(3) == 0) begin
               row = $urandom_range(127);
               col = $urandom_range(127);
            end else begin
               row = $urandom_range(oh - 1);
               col = $urandom_range(ow - 1);
            end
            compute(0, row, col, 1'($urandom_range(1)));
         end else if (kind == 5 && n_samples > 0)
            load(cbr_pkg::KIND_SAMPLE, $urandom_range(n_samples - 1), pick_value());
         else if (kind == 6 && n_weights > 0)
            load(cbr_pkg::KIND_WEIGHT, $urandom_range(n_weights - 1), pick_value());
         else if (kind == 7)
            load(cbr_pkg::KIND_BIAS, $urandom_range(BIAS_DEPTH, 16383), pick_value()); // ignored
         else
            load(cbr_pkg::KIND_BIAS, $urandom_range(BIAS_DEPTH - 1), pick_value());
      end
   endtask

   initial begin
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = cbr_pkg::KIND_SAMPLE;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = cbr_pkg::CSR_IN_CHANNELS;
      csr_wdata  = '0;
      sender_idle_pct   = 37;
      receiver_idle_pct = 47;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, biases of groups 0 and 1, extreme values and positions
      for (int i = 0; i < 16; i++) load(cbr_pkg::KIND_BIAS, i, pick_value());
      load(cbr_pkg::KIND_SAMPLE, 0, 16'h7fff);
      for (int i = 0; i < 16; i++)
         load(cbr_pkg::KIND_WEIGHT, i, (i % 2) ? 16'h8000 : 16'h7fff);
      load(cbr_pkg::KIND_BIAS, 0, 16'h8000);
      load(cbr_pkg::KIND_BIAS, 1, 16'h7fff);
      load(cbr_pkg::KIND_BIAS, 16383, 16'h1234);     // beyond the bias store, dropped
      compute(0, 0, 0, 1'b0);
      compute(0, 0, 0, 1'b1);
      compute(1, 127, 127, 1'b0);                    // group past out_groups, off the map
      compute(1, 0, 0, 1'b1);
      load(cbr_pkg::KIND_SAMPLE, 0, 16'h8000);
      compute(0, 0, 0, 1'b0);

      // sweep of settings: padding, dilation, stride, channel sums and zero-sized registers
      run_phase(1, 1, 3, 3, 2, 2, 1, 2, 8);
      sender_idle_pct   = 47;
      receiver_idle_pct = 37;
      run_phase(3, 8, 1, 1, 1, 3, 0, 2, 8);   // channel sum, saturates with extremes
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_phase(0, 1, 0, 128, 0, 1, 3, 1, 6); // zero counts, bias only

      drain();
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
